/* hw/rtl/jsu_pkg.sv */
// ============================================================================
// jsu_pkg: shared types and constants for the JSON string unescaper
// Byte codes, result kinds, UTF-8 lead patterns and the record of up to four
// result bytes that the decoder hands to the output side.
// ============================================================================
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int BYTE_W = 8;
    localparam int CAP_W  = 13;
    localparam int KIND_W = 2;

    // Destination size limit; a larger capacity saturates to this value
    localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Source byte codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Control codes produced by the simple escapes
    localparam logic [7:0] CC_BS = 8'h08;
    localparam logic [7:0] CC_FF = 8'h0C;
    localparam logic [7:0] CC_LF = 8'h0A;
    localparam logic [7:0] CC_CR = 8'h0D;
    localparam logic [7:0] CC_HT = 8'h09;

    // UTF-8 lead and continuation patterns
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    // Surrogate prefixes on code unit bits [15:10]
    localparam logic [5:0] SUR_HIGH = 6'b110110;
    localparam logic [5:0] SUR_LOW  = 6'b110111;
    // Offset of a joined pair above the basic plane, in units of 1024
    localparam logic [10:0] PAIR_BASE = 11'h040;

    // Decoupling queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Results caused by one source byte
    typedef struct packed {
        logic [3:0][BYTE_W-1:0] data;
        logic [2:0]             count;
        logic [KIND_W-1:0]      kind;
    } grp_t;

    typedef struct packed {
        logic push;
        grp_t grp;
    } q_wr_t;

    typedef struct packed {
        logic avail;
        grp_t grp;
    } q_rd_t;

endpackage

/* hw/rtl/jsu_if.sv */
// ============================================================================
// jsu_if: stream channels of the JSON string unescaper
// Source byte channel and result channel, each a valid/ready transfer.
// ============================================================================
`timescale 1ns / 1ps

interface jsu_in_if import jsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic [CAP_W-1:0]  capacity;
    logic              final_req;

    modport source (output valid, output in_byte, output capacity, output final_req,
                    input ready);
    modport sink   (input valid, input in_byte, input capacity, input final_req,
                    output ready);
endinterface

interface jsu_out_if import jsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              last;

    modport source (output valid, output out_byte, output kind, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last,
                    output ready);
endinterface

/* hw/rtl/jsu_front.sv */
// ============================================================================
// jsu_front: escape decoder
// Takes one source byte per cycle while the queue has room, tracks escapes,
// encodes code points as UTF-8 and pushes each byte's results as one entry.
// ============================================================================
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     src,
    input  logic       q_full,
    output q_wr_t      wr
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX,
        PH_PAIR_BS,
        PH_PAIR_U,
        PH_PAIR_HEX
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [15:0]      acc_reg, acc_next;
    logic [9:0]       hs_reg, hs_next;
    logic [1:0]       dc_reg, dc_next;
    logic [CAP_W-1:0] space_reg, space_next;

    logic             take;
    logic [4:0]       dig;
    logic [15:0]      acc_shift;
    logic             done;
    logic [KIND_W-1:0] done_kind;
    logic             put_byte;
    logic [7:0]       put_val;
    logic             put_cp;
    logic [20:0]      cp;
    logic [2:0]       need;
    grp_t             grp;

    // Return {valid, value} for an ASCII hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, ch[3:0]};
        end
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            r = {1'b1, ch[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign src.ready = !q_full;
    assign take      = src.valid && src.ready;
    assign dig       = hex_digit(src.in_byte);
    assign acc_shift = {acc_reg[11:0], dig[3:0]};

    // Decode the byte and build its results
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        dc_next    = dc_reg;
        space_next = space_reg;
        done       = 1'b0;
        done_kind  = KIND_ERROR;
        put_byte   = 1'b0;
        put_val    = src.in_byte;
        put_cp     = 1'b0;
        cp         = {5'd0, acc_shift};
        need       = 3'd1;
        grp.data   = '0;
        grp.count  = 3'd0;
        grp.kind   = KIND_DATA;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (src.in_byte != CH_QUOTE || src.capacity == '0) begin
                    done = 1'b1;
                end
                else begin
                    space_next = (src.capacity > MAX_CAPACITY) ? MAX_CAPACITY
                                                              : src.capacity;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                priority if (src.in_byte == CH_QUOTE) begin
                    done      = 1'b1;
                    done_kind = KIND_CLOSE;
                end
                else if (src.in_byte < CH_SPACE) begin
                    done = 1'b1;
                end
                else if (src.in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end
                else begin
                    put_byte = 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                unique case (src.in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: put_byte = 1'b1;
                    CH_LOW_B:
                    begin
                        put_byte = 1'b1;
                        put_val  = CC_BS;
                    end
                    CH_LOW_F:
                    begin
                        put_byte = 1'b1;
                        put_val  = CC_FF;
                    end
                    CH_LOW_N:
                    begin
                        put_byte = 1'b1;
                        put_val  = CC_LF;
                    end
                    CH_LOW_R:
                    begin
                        put_byte = 1'b1;
                        put_val  = CC_CR;
                    end
                    CH_LOW_T:
                    begin
                        put_byte = 1'b1;
                        put_val  = CC_HT;
                    end
                    CH_LOW_U:
                    begin
                        phase_next = PH_HEX;
                        acc_next   = '0;
                        dc_next    = '0;
                    end
                    default: done = 1'b1;
                endcase
            end
            PH_HEX, PH_PAIR_HEX:
            begin
                if (!dig[4]) begin
                    done = 1'b1;
                end
                else begin
                    acc_next = acc_shift;
                    dc_next  = dc_reg + 2'd1;
                    // Fourth digit completes the code unit
                    if (dc_reg == 2'd3) begin
                        if (phase_reg == PH_HEX) begin
                            if (acc_shift[15:10] == SUR_HIGH) begin
                                hs_next    = acc_shift[9:0];
                                phase_next = PH_PAIR_BS;
                            end
                            else if (acc_shift[15:10] == SUR_LOW) begin
                                done = 1'b1;
                            end
                            else begin
                                put_cp     = 1'b1;
                                phase_next = PH_BODY;
                            end
                        end
                        else begin
                            if (acc_shift[15:10] != SUR_LOW) begin
                                done = 1'b1;
                            end
                            else begin
                                put_cp     = 1'b1;
                                cp         = {11'(hs_reg) + PAIR_BASE, acc_shift[9:0]};
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
            end
            PH_PAIR_BS:
            begin
                if (src.in_byte == CH_BSLASH) begin
                    phase_next = PH_PAIR_U;
                end
                else begin
                    done = 1'b1;
                end
            end
            PH_PAIR_U:
            begin
                if (src.in_byte == CH_LOW_U) begin
                    phase_next = PH_PAIR_HEX;
                    acc_next   = '0;
                    dc_next    = '0;
                end
                else begin
                    done = 1'b1;
                end
            end
            default: done = 1'b1;
        endcase

        // Single byte: write only while room for it and the terminator
        if (put_byte && space_reg > 13'd1) begin
            grp.data[0] = put_val;
            grp.count   = 3'd1;
            space_next  = space_reg - 13'd1;
        end

        // Code point: write the whole sequence or drop it
        if (put_cp) begin
            if (cp[20:16] != '0) begin
                need = 3'd4;
            end
            else if (cp[15:11] != '0) begin
                need = 3'd3;
            end
            else if (cp[10:7] != '0) begin
                need = 3'd2;
            end
            else begin
                need = 3'd1;
            end
            if (space_reg > {10'd0, need}) begin
                space_next = space_reg - {10'd0, need};
                grp.count  = need;
                unique case (need)
                    3'd1: grp.data[0] = {1'b0, cp[6:0]};
                    3'd2:
                    begin
                        grp.data[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                        grp.data[1] = UTF8_CONT  | {2'd0, cp[5:0]};
                    end
                    3'd3:
                    begin
                        grp.data[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                        grp.data[1] = UTF8_CONT  | {2'd0, cp[11:6]};
                        grp.data[2] = UTF8_CONT  | {2'd0, cp[5:0]};
                    end
                    default:
                    begin
                        grp.data[0] = UTF8_LEAD4 | {5'd0, cp[20:18]};
                        grp.data[1] = UTF8_CONT  | {2'd0, cp[17:12]};
                        grp.data[2] = UTF8_CONT  | {2'd0, cp[11:6]};
                        grp.data[3] = UTF8_CONT  | {2'd0, cp[5:0]};
                    end
                endcase
            end
        end

        // Source ends inside the string
        if (!done && src.final_req) begin
            done      = 1'b1;
            done_kind = KIND_ERROR;
        end

        // Close or error: replace any data with a single status result
        if (done) begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            hs_next    = '0;
            dc_next    = '0;
            grp.data   = '0;
            grp.count  = 3'd1;
            grp.kind   = done_kind;
        end

        wr.push = take && (grp.count != 3'd0);
        wr.grp  = grp;
    end

    // Advance decoder state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            hs_reg    <= '0;
            dc_reg    <= '0;
            space_reg <= '0;
        end
        else if (take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
            dc_reg    <= dc_next;
            space_reg <= space_next;
        end
    end

endmodule

/* hw/rtl/jsu_queue.sv */
// ============================================================================
// jsu_queue: result group queue
// Short first-in first-out queue of result groups between decoder and
// serializer, so that each side stalls on its own.
// ============================================================================
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    input  logic  pop,
    output logic  full,
    output q_rd_t rd
);

    grp_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign do_push  = wr.push && !full;
    assign do_pop   = pop && (cnt_reg != '0);
    assign full     = (cnt_reg == (QAW+1)'(QDEPTH));
    assign rd.avail = (cnt_reg != '0);
    assign rd.grp   = slot_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (QAW+1)'(1);
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - (QAW+1)'(1);
        end
    end

    // Hold group payloads
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wptr_reg] <= wr.grp;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + QAW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* hw/rtl/jsu_back.sv */
// ============================================================================
// jsu_back: result serializer
// Walks the head group's bytes and presents one result per cycle, while dst
// is ready, from an output register; a group's last byte carries last.
// ============================================================================
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  q_rd_t      rd,
    output logic       pop,
    jsu_out_if.source  dst
);

    logic [1:0]        idx_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [KIND_W-1:0] kind_reg;
    logic              last_reg;
    logic              load;
    logic              at_end;

    assign load   = rd.avail && (!valid_reg || dst.ready);
    assign at_end = ({1'b0, idx_reg} == (rd.grp.count - 3'd1));
    assign pop    = load && at_end;

    assign dst.valid    = valid_reg;
    assign dst.out_byte = byte_reg;
    assign dst.kind     = kind_reg;
    assign dst.last     = last_reg;

    // Load the next byte of the head group
    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg <= rd.grp.data[idx_reg];
            kind_reg <= rd.grp.kind;
            last_reg <= at_end;
        end
    end

    // Track byte index and output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end
            else if (dst.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/json_string_unescape_utf8.sv */
// ============================================================================
// json_string_unescape_utf8: JSON string unescaper with UTF-8 output
// src carries one source byte per transfer; the opening quote comes with the
// destination capacity (terminator included). dst returns results: data
// bytes (kind 0), string closed (kind 1) or decode error (kind 2), with last
// set on the final result of each source byte. A byte may cause zero to four
// results; an error or close returns the decoder to waiting for a quote.
// Throughput: one source byte per cycle and one result per cycle; the
// decoder takes a byte whenever the four-entry group queue has room, so a
// run of multi-byte characters is limited by the single result per cycle of
// the serializer. A byte's results pass the group queue, then the output
// register. Reset clears the decoder, queue and output register.
// When dst stalls the result holds, the queue fills, and src.ready drops.
// ============================================================================
`timescale 1ns / 1ps

module json_string_unescape_utf8 import jsu_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    src,
    jsu_out_if.source dst
);

    q_wr_t wr;
    q_rd_t rd;
    logic  q_full;
    logic  pop;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .src    (src),
        .q_full (q_full),
        .wr     (wr)
    );

    jsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (q_full),
        .rd    (rd)
    );

    jsu_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rd),
        .pop   (pop),
        .dst   (dst)
    );

endmodule

/* hw/rtl/jsu_checker.sv */
// ============================================================================
// jsu_checker: port-level checks for the JSON string unescaper
// Watches the result channel for stalls, status result form and reset.
// ============================================================================
`timescale 1ns / 1ps

module jsu_checker import jsu_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] out_byte,
    input logic [KIND_W-1:0] kind,
    input logic              last
);

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(kind) && $stable(last))
        else $error("result changed while stalled");

    // Close and error results stand alone with a zero byte
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> last && out_byte == '0 &&
        (kind == KIND_CLOSE || kind == KIND_ERROR))
        else $error("malformed status result");

    // No result on the first edge after reset release
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (dst.valid),
    .out_ready (dst.ready),
    .out_byte  (dst.out_byte),
    .kind      (dst.kind),
    .last      (dst.last)
);
